@@ sv/clt_pkg.sv @@
// Package for the command line tokenizer.
// Holds the shared widths, codes, the scan mode type and the result record.
// Used by every module of the block.
package clt_pkg;

  localparam int MAX_ARGS   = 63;
  localparam int LINE_BYTES = 1024;

  localparam int OFF_W   = $clog2(LINE_BYTES + 1);
  localparam int START_W = $clog2(LINE_BYTES);
  localparam int LEN_W   = $clog2(LINE_BYTES + 1);
  localparam int ARG_W   = $clog2(MAX_ARGS + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_ARG       = 2'd0;
  localparam logic [1:0] KIND_IN_REDIR  = 2'd1;
  localparam logic [1:0] KIND_OUT_REDIR = 2'd2;
  localparam logic [1:0] KIND_CMD_END   = 2'd3;

  localparam logic [1:0] TERM_NUL  = 2'd0;
  localparam logic [1:0] TERM_AMP  = 2'd1;
  localparam logic [1:0] TERM_PIPE = 2'd2;

  localparam logic [1:0] CFG_R1_LOW  = 2'd0;
  localparam logic [1:0] CFG_R1_HIGH = 2'd1;
  localparam logic [1:0] CFG_R2_LOW  = 2'd2;
  localparam logic [1:0] CFG_R2_HIGH = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'd0,
    MODE_TOKEN   = 3'd1,
    MODE_QUOTE   = 3'd2,
    MODE_TRAIL   = 3'd3,
    MODE_MARK    = 3'd4,
    MODE_WAIT    = 3'd5
  } scan_mode_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic [ARG_W-1:0]   index;
    logic [1:0]         term;
    logic               append;
    logic               error;
    logic               overflow;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ sv/clt_front.sv @@
// Front end of the command line tokenizer: takes bytes, tracks the scan state
// and forms up to two result records per byte for the queue.
// Depends on clt_pkg.
module clt_front import clt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       char_valid,
  output logic       char_ready,
  input  logic [7:0] char_byte,
  input  logic       room,
  output push_t      push
);

  logic [7:0] r1_low, r1_high, r2_low, r2_high;

  scan_mode_t       scan_mode, mode_next;
  logic [1:0]       token_kind, kind_next;
  logic [OFF_W-1:0] token_begin, begin_next;
  logic [OFF_W-1:0] byte_offset;
  logic [ARG_W-1:0] arg_count, count_after;
  logic             append_seen, append_next;
  logic             overflow_seen, ovf_after;

  logic accept;
  logic b_space, b_end, b_lead, b_quote, b_nul;
  logic emit_tok, end_cmd, err;
  logic tok_is_arg, arg_full;
  result_t tok_rec, end_rec;
  logic [1:0] n_res;

  assign char_ready = room;
  assign accept     = char_valid && char_ready;

  assign b_nul   = (char_byte == CH_NUL);
  assign b_quote = (char_byte == CH_QUOTE);
  assign b_end   = (char_byte inside {CH_NUL, CH_AMP, CH_PIPE});
  assign b_space = (char_byte inside {8'h20, [8'h09:8'h0D]});
  assign b_lead  = ((char_byte >= r1_low) && (char_byte <= r1_high)) ||
                   ((char_byte >= r2_low) && (char_byte <= r2_high));

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_low  <= 8'd129;
      r1_high <= 8'd159;
      r2_low  <= 8'd224;
      r2_high <= 8'd252;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_R1_LOW:  r1_low  <= cfg_data;
        CFG_R1_HIGH: r1_high <= cfg_data;
        CFG_R2_LOW:  r2_low  <= cfg_data;
        CFG_R2_HIGH: r2_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next = scan_mode;
    case (scan_mode)
      MODE_TOKEN: begin
        if (b_end || b_space) mode_next = MODE_BETWEEN;
        else if (b_quote) mode_next = MODE_QUOTE;
        else if (b_lead) mode_next = MODE_TRAIL;
      end
      MODE_QUOTE: begin
        if (b_quote) mode_next = MODE_TOKEN;
      end
      MODE_TRAIL: begin
        mode_next = b_nul ? MODE_BETWEEN : MODE_TOKEN;
      end
      MODE_MARK, MODE_WAIT: begin
        if (scan_mode == MODE_MARK && char_byte == CH_GT) mode_next = MODE_WAIT;
        else if (b_end) mode_next = MODE_BETWEEN;
        else if (b_space) mode_next = MODE_WAIT;
        else if (b_quote) mode_next = MODE_QUOTE;
        else if (b_lead) mode_next = MODE_TRAIL;
        else mode_next = MODE_TOKEN;
      end
      default: begin
        if (b_end || b_space) mode_next = MODE_BETWEEN;
        else if (char_byte == CH_LT || char_byte == CH_GT) mode_next = MODE_MARK;
        else if (b_quote) mode_next = MODE_QUOTE;
        else if (b_lead) mode_next = MODE_TRAIL;
        else mode_next = MODE_TOKEN;
      end
    endcase
  end

  always_comb begin
    emit_tok    = 1'b0;
    end_cmd     = 1'b0;
    err         = 1'b0;
    kind_next   = token_kind;
    begin_next  = token_begin;
    append_next = append_seen;
    case (scan_mode)
      MODE_TOKEN: begin
        if (b_end) begin
          emit_tok = 1'b1;
          end_cmd  = 1'b1;
        end else if (b_space) begin
          emit_tok = 1'b1;
        end
      end
      MODE_QUOTE, MODE_TRAIL: begin
        if (b_nul) begin
          emit_tok = 1'b1;
          end_cmd  = 1'b1;
        end
      end
      MODE_MARK, MODE_WAIT: begin
        if (scan_mode == MODE_MARK && char_byte == CH_GT) begin
          append_next = 1'b1;
        end else if (b_end) begin
          end_cmd = 1'b1;
          err     = 1'b1;
        end else if (!b_space) begin
          begin_next = byte_offset;
        end
      end
      default: begin
        if (b_end) begin
          end_cmd = 1'b1;
        end else if (b_space) begin
          kind_next = token_kind;
        end else if (char_byte == CH_LT) begin
          kind_next = KIND_IN_REDIR;
        end else if (char_byte == CH_GT) begin
          kind_next = KIND_OUT_REDIR;
        end else begin
          kind_next  = KIND_ARG;
          begin_next = byte_offset;
        end
      end
    endcase
  end

  assign tok_is_arg  = (token_kind == KIND_ARG);
  assign arg_full    = (arg_count >= ARG_W'(MAX_ARGS));
  assign count_after = (emit_tok && tok_is_arg && !arg_full) ? arg_count + 1'b1 : arg_count;
  assign ovf_after   = overflow_seen || (emit_tok && tok_is_arg && arg_full);

  always_comb begin
    tok_rec.kind     = token_kind;
    tok_rec.start    = (token_begin > OFF_W'(LINE_BYTES - 1)) ?
                       START_W'(LINE_BYTES - 1) : token_begin[START_W-1:0];
    tok_rec.length   = (byte_offset >= token_begin) ?
                       LEN_W'(byte_offset - token_begin) : '0;
    tok_rec.index    = !tok_is_arg ? '0 : (arg_full ? ARG_W'(MAX_ARGS) : arg_count);
    tok_rec.term     = TERM_NUL;
    tok_rec.append   = tok_is_arg ? 1'b0 : append_seen;
    tok_rec.error    = 1'b0;
    tok_rec.overflow = ovf_after;
    tok_rec.last     = !end_cmd;

    end_rec.kind     = KIND_CMD_END;
    end_rec.start    = '0;
    end_rec.length   = '0;
    end_rec.index    = count_after;
    end_rec.term     = (char_byte == CH_AMP) ? TERM_AMP :
                       ((char_byte == CH_PIPE) ? TERM_PIPE : TERM_NUL);
    end_rec.append   = append_seen;
    end_rec.error    = err;
    end_rec.overflow = ovf_after;
    end_rec.last     = 1'b1;
  end

  assign n_res        = {1'b0, emit_tok} + {1'b0, end_cmd};
  assign push.count   = accept ? n_res : 2'd0;
  assign push.first   = emit_tok ? tok_rec : end_rec;
  assign push.second  = end_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_BETWEEN;
      token_kind    <= KIND_ARG;
      token_begin   <= '0;
      byte_offset   <= '0;
      arg_count     <= '0;
      append_seen   <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (end_cmd) begin
        scan_mode     <= MODE_BETWEEN;
        token_kind    <= KIND_ARG;
        token_begin   <= '0;
        byte_offset   <= '0;
        arg_count     <= '0;
        append_seen   <= 1'b0;
        overflow_seen <= 1'b0;
      end else begin
        scan_mode     <= mode_next;
        token_kind    <= kind_next;
        token_begin   <= begin_next;
        append_seen   <= append_next;
        arg_count     <= count_after;
        overflow_seen <= ovf_after;
        if (byte_offset < OFF_W'(LINE_BYTES)) byte_offset <= byte_offset + 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_two_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> end_cmd)
    else $error("two results pushed without a command end");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_cmd) |=> (byte_offset == '0 && arg_count == '0 && !overflow_seen))
    else $error("command end did not clear the scan state");

  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    byte_offset <= OFF_W'(LINE_BYTES))
    else $error("byte offset beyond line length");
`endif

endmodule

@@ sv/clt_queue.sv @@
// Result queue between the tokenizer front end and the output stage.
// Takes up to two records per cycle and hands out one. Depends on clt_pkg.
module clt_queue import clt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    q_valid,
  output result_t q_data,
  input  logic    q_pop
);

  result_t mem [QDEPTH];
  logic [QPTR_W-1:0] head, tail, tail_plus;
  logic [QCNT_W-1:0] count;

  assign tail_plus = tail + 1'b1;
  assign room      = (count <= QCNT_W'(QDEPTH - 2));
  assign q_valid   = (count != '0);
  assign q_data    = mem[head];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[tail] <= push.first;
    if (push.count == 2'd2) mem[tail_plus] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPTR_W'(push.count);
      if (q_pop) head <= head + 1'b1;
      count <= count + QCNT_W'(push.count) - QCNT_W'(q_pop);
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (count + QCNT_W'(push.count)) <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != '0))
    else $error("pop from empty queue");
`endif

endmodule

@@ sv/clt_back.sv @@
// Output stage of the command line tokenizer: registers one result record
// and presents it on the result channel. Depends on clt_pkg.
module clt_back import clt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  result_t            q_data,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         result_kind,
  output logic [START_W-1:0] token_start,
  output logic [LEN_W-1:0]   token_length,
  output logic [ARG_W-1:0]   arg_index,
  output logic [1:0]         terminator_code,
  output logic               append_mode,
  output logic               redirect_error,
  output logic               args_overflow,
  output logic               last_result
);

  result_t held;
  logic    take;

  assign take  = !result_valid || result_ready;
  assign q_pop = q_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) held <= q_data;
  end

  assign result_kind     = held.kind;
  assign token_start     = held.start;
  assign token_length    = held.length;
  assign arg_index       = held.index;
  assign terminator_code = held.term;
  assign append_mode     = held.append;
  assign redirect_error  = held.error;
  assign args_overflow   = held.overflow;
  assign last_result     = held.last;

endmodule

@@ sv/command_line_tokenizer_unit.sv @@
// Command line tokenizer: takes one byte of a command line per cycle and
// returns a record for each finished token and one for each command end.
// A byte is taken every cycle while the four-entry result queue has room for
// two records; the output register drains one record per cycle while
// result_ready is high, so a byte that both closes a token and ends the command
// leaves two records to drain. A record passes through the result queue and
// then the output register. Depends on clt_pkg, clt_front, clt_queue and clt_back.
module command_line_tokenizer_unit import clt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               char_valid,
  output logic               char_ready,
  input  logic [7:0]         char_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [1:0]         result_kind,
  output logic [START_W-1:0] token_start,
  output logic [LEN_W-1:0]   token_length,
  output logic [ARG_W-1:0]   arg_index,
  output logic [1:0]         terminator_code,
  output logic               append_mode,
  output logic               redirect_error,
  output logic               args_overflow,
  output logic               last_result
);

  push_t   push;
  logic    room;
  logic    q_valid;
  logic    q_pop;
  result_t q_data;

  clt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_byte  (char_byte),
    .room       (room),
    .push       (push)
  );

  clt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  clt_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_kind     (result_kind),
    .token_start     (token_start),
    .token_length    (token_length),
    .arg_index       (arg_index),
    .terminator_code (terminator_code),
    .append_mode     (append_mode),
    .redirect_error  (redirect_error),
    .args_overflow   (args_overflow),
    .last_result     (last_result)
  );

endmodule
